// ----- design/ffpa_pkg.sv -----
package ffpa_pkg;

    localparam int GRANULE_SHIFT = 4;
    localparam int HDR_G         = 3;
    localparam int MIN_SPLIT_G   = 1;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_REFUSED  = 3'd1;
    localparam logic [2:0] ST_NULL     = 3'd2;
    localparam logic [2:0] ST_BAD_HDR  = 3'd3;
    localparam logic [2:0] ST_DBL_FREE = 3'd4;

    typedef enum logic [17:0] {
        S_CLR     = 18'h00001,
        S_IDLE    = 18'h00002,
        S_A_SRD   = 18'h00004,
        S_A_SCHK  = 18'h00008,
        S_A_GADD  = 18'h00010,
        S_A_GCHK  = 18'h00020,
        S_A_SPLIT = 18'h00040,
        S_A_WG    = 18'h00080,
        S_F_CG    = 18'h00100,
        S_F_RNX   = 18'h00200,
        S_F_CNX   = 18'h00400,
        S_F_RP    = 18'h00800,
        S_F_CP    = 18'h01000,
        S_F_WG    = 18'h02000,
        S_SP_RD   = 18'h04000,
        S_SP_WR   = 18'h08000,
        S_DONE    = 18'h10000,
        S_SPARE   = 18'h20000
    } state_t;

endpackage

// ----- design/first_fit_pool_allocator.sv -----
// Flow: a zero-size alloc, a null free or a malformed free address answers in the cycle after
//   the transfer; a free merges with free neighbors above and below; an allocation walks
//   block records first-fit, relinks above a split and grows by whole chunks when no block fits.
// Throughput: one request at a time; the block-record memory accesses set the pace.
// Reset: asynchronous, active low; afterwards a clearing pass writes every record, one per
//   cycle (ARENA_BYTES/16 records), while no request is taken.
module first_fit_pool_allocator #(
    parameter int ARENA_BYTES = 1048576,
    parameter int CHUNK_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [19:0] size,
    input  logic [31:0] tag,
    input  logic [19:0] address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [19:0] payload_offset,
    output logic [20:0] bytes_in_use,
    output logic [20:0] committed_bytes,
    output logic        corruption_seen,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);

    // Granule bookkeeping: records are indexed by start granule.
    localparam int NGRAN   = ARENA_BYTES / 16;
    localparam int GW      = $clog2(NGRAN);
    localparam int SW      = GW + 1;
    localparam int CW      = GW + 1;
    localparam int BW      = GW + 5;
    localparam int PW      = (GW + 6 > 19) ? GW + 6 : 19;
    localparam int CHUNK_G = CHUNK_BYTES / 16;
    localparam int INIT_G  = ((CHUNK_BYTES > ARENA_BYTES) ? ARENA_BYTES : CHUNK_BYTES) / 16;

    typedef struct packed {
        logic          valid;
        logic          free;
        logic [SW-1:0] size;
        logic [GW-1:0] prev;
    } entry_t;

    localparam entry_t INIT_ENTRY = '{valid: 1'b1, free: 1'b1,
                                      size: SW'(INIT_G - ffpa_pkg::HDR_G), prev: '0};

    // Block records and owner tags.
    entry_t      info_mem [NGRAN];
    logic [31:0] owner_mem [NGRAN];
    entry_t      rd_reg;

    logic          mem_we;
    logic [GW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic          mem_re;
    logic [GW-1:0] mem_raddr;
    logic          own_we;

    ffpa_pkg::state_t state_reg, state_next;
    ffpa_pkg::state_t ret_reg, ret_next;

    logic [GW-1:0] clr_reg, clr_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] need_reg, need_next;
    logic [PW-1:0] want_reg, want_next;
    logic [GW-1:0] g_reg, g_next;
    logic [SW-1:0] gsize_reg, gsize_next;
    logic [GW-1:0] gprev_reg, gprev_next;
    logic          split_reg, split_next;
    logic          retry_reg, retry_next;
    logic          dead_reg, dead_next;
    logic [GW-1:0] sp_addr_reg, sp_addr_next;
    logic [GW-1:0] sp_val_reg, sp_val_next;
    logic [31:0]   tag_reg, tag_next;
    logic [GW-1:0] tail_reg, tail_next;
    logic [CW-1:0] cend_reg, cend_next;
    logic [BW-1:0] used_reg, used_next;
    logic          broken_reg, broken_next;
    logic [4:0]    limit_reg;
    logic          out_valid_reg, out_valid_next;
    logic [2:0]    status_reg, status_next;
    logic [19:0]   off_reg, off_next;

    logic          accept;
    logic [PW-1:0] cend_w;
    logic [PW-1:0] need_calc;
    logic [PW-1:0] free_g;
    logic [PW-1:0] lim_raw;
    logic [PW-1:0] lim_g;
    logic [PW-1:0] after_w;
    logic [SW-1:0] merged_w;

    assign cfg_ready       = 1'b1;
    assign in_stall        = (state_reg != ffpa_pkg::S_IDLE) || (out_valid_reg && out_stall);
    assign accept          = in_valid && !in_stall;
    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign payload_offset  = off_reg;
    assign bytes_in_use    = 21'(used_reg);
    assign committed_bytes = 21'({cend_reg, 4'b0000});
    assign corruption_seen = broken_reg;

    assign cend_w    = PW'(cend_reg);
    assign need_calc = PW'((21'(size) + 21'd15) >> ffpa_pkg::GRANULE_SHIFT) + PW'(1);
    assign free_g    = PW'(address[19:4]) - PW'(ffpa_pkg::HDR_G);
    assign lim_raw   = PW'(limit_reg) * PW'(CHUNK_G);
    assign lim_g     = (lim_raw > PW'(NGRAN)) ? PW'(NGRAN) : lim_raw;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            info_mem[mem_waddr] <= mem_wdata;
        end
        if (own_we)
        begin
            owner_mem[g_reg] <= tag_reg;
        end
        if (mem_re)
        begin
            rd_reg <= info_mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        clr_next       = clr_reg;
        pos_next       = pos_reg;
        need_next      = need_reg;
        want_next      = want_reg;
        g_next         = g_reg;
        gsize_next     = gsize_reg;
        gprev_next     = gprev_reg;
        split_next     = split_reg;
        retry_next     = retry_reg;
        dead_next      = dead_reg;
        sp_addr_next   = sp_addr_reg;
        sp_val_next    = sp_val_reg;
        tag_next       = tag_reg;
        tail_next      = tail_reg;
        cend_next      = cend_reg;
        used_next      = used_reg;
        broken_next    = broken_reg;
        status_next    = status_reg;
        off_next       = off_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        own_we         = 1'b0;
        after_w        = '0;
        merged_w       = '0;

        // Drop the result once the consumer takes it.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ffpa_pkg::S_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = (clr_reg == '0) ? INIT_ENTRY : '0;
                clr_next  = clr_reg + GW'(1);
                if (clr_reg == GW'(NGRAN - 1))
                begin
                    state_next = ffpa_pkg::S_IDLE;
                end
            end
            ffpa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    off_next = '0;
                    if (mode == ffpa_pkg::MODE_ALLOC)
                    begin
                        if (size == '0)
                        begin
                            status_next    = ffpa_pkg::ST_REFUSED;
                            out_valid_next = 1'b1;
                        end
                        else
                        begin
                            need_next  = need_calc;
                            pos_next   = '0;
                            retry_next = 1'b0;
                            tag_next   = tag;
                            state_next = ffpa_pkg::S_A_SRD;
                        end
                    end
                    else if (address == '0)
                    begin
                        status_next    = ffpa_pkg::ST_NULL;
                        out_valid_next = 1'b1;
                    end
                    else if (address[3:0] != 4'd0 || address < 20'd48 || free_g >= cend_w)
                    begin
                        broken_next    = 1'b1;
                        status_next    = ffpa_pkg::ST_BAD_HDR;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = free_g[GW-1:0];
                        g_next     = free_g[GW-1:0];
                        state_next = ffpa_pkg::S_F_CG;
                    end
                end
            end
            // First-fit walk: issue a record read, then check it.
            ffpa_pkg::S_A_SRD:
            begin
                if (pos_reg < cend_w)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = pos_reg[GW-1:0];
                    state_next = ffpa_pkg::S_A_SCHK;
                end
                else if (retry_reg)
                begin
                    status_next = ffpa_pkg::ST_REFUSED;
                    state_next  = ffpa_pkg::S_DONE;
                end
                else
                begin
                    want_next  = PW'(CHUNK_G);
                    state_next = ffpa_pkg::S_A_GADD;
                end
            end
            ffpa_pkg::S_A_SCHK:
            begin
                if (!rd_reg.valid)
                begin
                    if (retry_reg)
                    begin
                        status_next = ffpa_pkg::ST_REFUSED;
                        state_next  = ffpa_pkg::S_DONE;
                    end
                    else
                    begin
                        want_next  = PW'(CHUNK_G);
                        state_next = ffpa_pkg::S_A_GADD;
                    end
                end
                else if (rd_reg.free && PW'(rd_reg.size) >= need_reg)
                begin
                    g_next     = pos_reg[GW-1:0];
                    gsize_next = rd_reg.size;
                    gprev_next = rd_reg.prev;
                    state_next = ffpa_pkg::S_A_SPLIT;
                end
                else
                begin
                    pos_next   = pos_reg + PW'(ffpa_pkg::HDR_G) + PW'(rd_reg.size);
                    state_next = ffpa_pkg::S_A_SRD;
                end
            end
            // Round the growth up to whole chunks, one chunk per cycle.
            ffpa_pkg::S_A_GADD:
            begin
                if (want_reg < need_reg + PW'(ffpa_pkg::HDR_G))
                begin
                    want_next = want_reg + PW'(CHUNK_G);
                end
                else if (cend_w + want_reg > lim_g)
                begin
                    status_next = ffpa_pkg::ST_REFUSED;
                    state_next  = ffpa_pkg::S_DONE;
                end
                else
                begin
                    cend_next  = CW'(cend_w + want_reg);
                    pos_next   = cend_w;
                    mem_re     = 1'b1;
                    mem_raddr  = tail_reg;
                    state_next = ffpa_pkg::S_A_GCHK;
                end
            end
            ffpa_pkg::S_A_GCHK:
            begin
                if (rd_reg.valid && rd_reg.free)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = tail_reg;
                    mem_wdata      = rd_reg;
                    mem_wdata.size = SW'(PW'(rd_reg.size) + want_reg);
                end
                else if (pos_reg < PW'(NGRAN))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pos_reg[GW-1:0];
                    mem_wdata = '{valid: 1'b1, free: 1'b1,
                                  size: SW'(want_reg - PW'(ffpa_pkg::HDR_G)), prev: tail_reg};
                    tail_next = pos_reg[GW-1:0];
                end
                pos_next   = '0;
                retry_next = 1'b1;
                state_next = ffpa_pkg::S_A_SRD;
            end
            ffpa_pkg::S_A_SPLIT:
            begin
                split_next = 1'b0;
                if (PW'(gsize_reg) >= need_reg + PW'(ffpa_pkg::HDR_G + ffpa_pkg::MIN_SPLIT_G))
                begin
                    after_w   = PW'(g_reg) + PW'(ffpa_pkg::HDR_G) + need_reg;
                    mem_we    = 1'b1;
                    mem_waddr = after_w[GW-1:0];
                    mem_wdata = '{valid: 1'b1, free: 1'b1,
                                  size: SW'(PW'(gsize_reg) - need_reg - PW'(ffpa_pkg::HDR_G)),
                                  prev: g_reg};
                    split_next   = 1'b1;
                    sp_val_next  = after_w[GW-1:0];
                    pos_next     = PW'(g_reg) + PW'(ffpa_pkg::HDR_G) + PW'(gsize_reg);
                    sp_addr_next = pos_next[GW-1:0];
                    gsize_next   = SW'(need_reg);
                end
                state_next = ffpa_pkg::S_A_WG;
            end
            ffpa_pkg::S_A_WG:
            begin
                mem_we      = 1'b1;
                mem_waddr   = g_reg;
                mem_wdata   = '{valid: 1'b1, free: 1'b0, size: gsize_reg, prev: gprev_reg};
                own_we      = 1'b1;
                used_next   = used_reg + (BW'(gsize_reg) << ffpa_pkg::GRANULE_SHIFT);
                status_next = ffpa_pkg::ST_OK;
                off_next    = 20'((PW'(g_reg) + PW'(ffpa_pkg::HDR_G)) << ffpa_pkg::GRANULE_SHIFT);
                state_next  = ffpa_pkg::S_DONE;
                if (split_reg)
                begin
                    if (pos_reg < cend_w)
                    begin
                        ret_next   = ffpa_pkg::S_DONE;
                        state_next = ffpa_pkg::S_SP_RD;
                    end
                    else
                    begin
                        tail_next = sp_val_reg;
                    end
                end
            end
            ffpa_pkg::S_F_CG:
            begin
                if (!rd_reg.valid)
                begin
                    broken_next = 1'b1;
                    status_next = ffpa_pkg::ST_BAD_HDR;
                    state_next  = ffpa_pkg::S_DONE;
                end
                else if (rd_reg.free)
                begin
                    status_next = ffpa_pkg::ST_DBL_FREE;
                    state_next  = ffpa_pkg::S_DONE;
                end
                else
                begin
                    gsize_next  = rd_reg.size;
                    gprev_next  = rd_reg.prev;
                    dead_next   = 1'b0;
                    status_next = ffpa_pkg::ST_OK;
                    used_next   = used_reg - (BW'(rd_reg.size) << ffpa_pkg::GRANULE_SHIFT);
                    pos_next    = PW'(g_reg) + PW'(ffpa_pkg::HDR_G) + PW'(rd_reg.size);
                    state_next  = ffpa_pkg::S_F_RNX;
                end
            end
            ffpa_pkg::S_F_RNX:
            begin
                if (pos_reg < cend_w)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = pos_reg[GW-1:0];
                    state_next = ffpa_pkg::S_F_CNX;
                end
                else
                begin
                    state_next = ffpa_pkg::S_F_RP;
                end
            end
            // Merge with the free neighbor above.
            ffpa_pkg::S_F_CNX:
            begin
                state_next = ffpa_pkg::S_F_RP;
                if (rd_reg.valid && rd_reg.free)
                begin
                    merged_w   = SW'(PW'(gsize_reg) + PW'(ffpa_pkg::HDR_G) + PW'(rd_reg.size));
                    gsize_next = merged_w;
                    mem_we     = 1'b1;
                    mem_waddr  = pos_reg[GW-1:0];
                    mem_wdata  = '0;
                    after_w    = PW'(g_reg) + PW'(ffpa_pkg::HDR_G) + PW'(merged_w);
                    if (after_w < cend_w)
                    begin
                        sp_addr_next = after_w[GW-1:0];
                        sp_val_next  = g_reg;
                        ret_next     = ffpa_pkg::S_F_RP;
                        state_next   = ffpa_pkg::S_SP_RD;
                    end
                    else
                    begin
                        tail_next = g_reg;
                    end
                end
            end
            ffpa_pkg::S_F_RP:
            begin
                if (g_reg != '0 && gprev_reg < g_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = gprev_reg;
                    state_next = ffpa_pkg::S_F_CP;
                end
                else
                begin
                    state_next = ffpa_pkg::S_F_WG;
                end
            end
            // Merge into the free neighbor below.
            ffpa_pkg::S_F_CP:
            begin
                if (rd_reg.valid && rd_reg.free)
                begin
                    merged_w       = SW'(PW'(rd_reg.size) + PW'(ffpa_pkg::HDR_G) + PW'(gsize_reg));
                    mem_we         = 1'b1;
                    mem_waddr      = gprev_reg;
                    mem_wdata      = rd_reg;
                    mem_wdata.size = merged_w;
                    dead_next      = 1'b1;
                    pos_next       = PW'(gprev_reg) + PW'(ffpa_pkg::HDR_G) + PW'(merged_w);
                end
                state_next = ffpa_pkg::S_F_WG;
            end
            ffpa_pkg::S_F_WG:
            begin
                mem_we     = 1'b1;
                mem_waddr  = g_reg;
                state_next = ffpa_pkg::S_DONE;
                if (dead_reg)
                begin
                    mem_wdata = '0;
                    if (pos_reg < cend_w)
                    begin
                        sp_addr_next = pos_reg[GW-1:0];
                        sp_val_next  = gprev_reg;
                        ret_next     = ffpa_pkg::S_DONE;
                        state_next   = ffpa_pkg::S_SP_RD;
                    end
                    else
                    begin
                        tail_next = gprev_reg;
                    end
                end
                else
                begin
                    mem_wdata = '{valid: 1'b1, free: 1'b1, size: gsize_reg, prev: gprev_reg};
                end
            end
            // Relink the lower-neighbor field of the block that follows.
            ffpa_pkg::S_SP_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = sp_addr_reg;
                state_next = ffpa_pkg::S_SP_WR;
            end
            ffpa_pkg::S_SP_WR:
            begin
                if (rd_reg.valid)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = sp_addr_reg;
                    mem_wdata      = rd_reg;
                    mem_wdata.prev = sp_val_reg;
                end
                state_next = ret_reg;
            end
            ffpa_pkg::S_DONE:
            begin
                out_valid_next = 1'b1;
                state_next     = ffpa_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ffpa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffpa_pkg::S_CLR;
            ret_reg       <= ffpa_pkg::S_DONE;
            clr_reg       <= '0;
            tail_reg      <= '0;
            cend_reg      <= CW'(INIT_G);
            used_reg      <= '0;
            broken_reg    <= 1'b0;
            limit_reg     <= 5'd16;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            clr_reg       <= clr_next;
            tail_reg      <= tail_next;
            cend_reg      <= cend_next;
            used_reg      <= used_next;
            broken_reg    <= broken_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        need_reg    <= need_next;
        want_reg    <= want_next;
        g_reg       <= g_next;
        gsize_reg   <= gsize_next;
        gprev_reg   <= gprev_next;
        split_reg   <= split_next;
        retry_reg   <= retry_next;
        dead_reg    <= dead_next;
        sp_addr_reg <= sp_addr_next;
        sp_val_reg  <= sp_val_next;
        tag_reg     <= tag_next;
        status_reg  <= status_next;
        off_reg     <= off_next;
    end

endmodule
